[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Both sample on clk and are held off while
// rst_n is low. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever ante holds, cons must hold.
`define QN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define QN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define QN_ASSERT_IMPL(lbl, ante, cons, msg)
`define QN_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/qnorm_pkg.sv]
// ----------------------------------------------------------------------------
// qnorm_pkg
// Widths, constants and helpers shared by the quaternion normalizer.
// ----------------------------------------------------------------------------
package qnorm_pkg;

  localparam int NCOMP         = 4;
  localparam int COMP_W        = 32;
  localparam int OUT_FRAC_BITS = 30;
  localparam int SH_W          = 5;

  localparam int SQ_W   = 2 * COMP_W;          // one square
  localparam int SUM_W  = SQ_W + 1;            // sum of four squares
  localparam int RAD_W  = SUM_W - 2;           // sum / 4
  localparam int ROOT_W = 32;                  // one root bit per stage
  localparam int RADP_W = 2 * ROOT_W;          // radicand padded to digit pairs
  localparam int SREM_W = ROOT_W + 4;          // square root remainder
  localparam int NUM_W  = COMP_W + OUT_FRAC_BITS;
  localparam int QUO_W  = 32;                  // one quotient bit per stage
  localparam int DIV_W  = ROOT_W + 1;          // divisor 2*root

  typedef logic        [COMP_W-1:0] mag_t;
  typedef logic signed [COMP_W-1:0] comp_t;

  localparam mag_t UNIT_ONE = mag_t'(1) << OUT_FRAC_BITS;

  // Left shift that brings a nonzero largest magnitude to at least 2^(COMP_W-2).
  function automatic logic [SH_W-1:0] norm_shift(input mag_t top);
    logic [SH_W-1:0] s;
    s = '0;
    for (int b = 0; b < COMP_W - 2; b++) begin
      if (top[b]) s = SH_W'(COMP_W - 2 - b);
    end
    if (top[COMP_W-1] || top[COMP_W-2]) s = '0;
    return s;
  endfunction

endpackage

[hw/rtl/qnorm_if.sv]
// ----------------------------------------------------------------------------
// qnorm_if
// Valid/ready channels for quaternion beats and unit quaternion beats.
// ----------------------------------------------------------------------------
interface qnorm_in_if;
  import qnorm_pkg::*;

  logic  valid;
  logic  ready;
  comp_t comp_w;
  comp_t comp_x;
  comp_t comp_y;
  comp_t comp_z;

  modport source (output valid, comp_w, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

interface qnorm_out_if;
  import qnorm_pkg::*;

  logic  valid;
  logic  ready;
  comp_t unit_w;
  comp_t unit_x;
  comp_t unit_y;
  comp_t unit_z;
  logic  was_zero;

  modport source (output valid, unit_w, unit_x, unit_y, unit_z, was_zero, input ready);
  modport sink   (input valid, unit_w, unit_x, unit_y, unit_z, was_zero, output ready);
endinterface

[hw/rtl/quaternion_normalizer.sv]
// Throughput: one beat per cycle unless the output stalls; the 32-stage root
// and 32-stage divide pipelines each retire one bit per stage.
// A beat passes stages A to F, root, G, divide and the output register.
// Backpressure freezes every stage at once; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data is not cleared.
// ----------------------------------------------------------------------------
// quaternion_normalizer
// Scales a Q16.16 quaternion to unit length, giving Q1.30 components.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_normalizer (
  input logic         clk,
  input logic         rst_n,
  qnorm_in_if.sink    in_ch,
  qnorm_out_if.source out_ch
);
  import qnorm_pkg::*;

  // Advance the whole pipe unless a finished beat sits unclaimed at the output.
  logic adv;
  logic out_vld_r;
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- stage A: magnitudes and signs --------------------------------------
  comp_t in_comp [NCOMP];
  mag_t  a_a_r   [NCOMP];
  logic [NCOMP-1:0] neg_a_r;
  logic             vld_a_r;

  assign in_comp[0] = in_ch.comp_w;
  assign in_comp[1] = in_ch.comp_x;
  assign in_comp[2] = in_ch.comp_y;
  assign in_comp[3] = in_ch.comp_z;

  // ---- stage B: normalizing shift -----------------------------------------
  mag_t top_01, top_23, top_all;
  mag_t a_b_r [NCOMP];
  logic [SH_W-1:0]  sh_b_r;
  logic [NCOMP-1:0] neg_b_r;
  logic             zero_b_r, vld_b_r;

  always_comb begin
    top_01  = (a_a_r[0] > a_a_r[1]) ? a_a_r[0] : a_a_r[1];
    top_23  = (a_a_r[2] > a_a_r[3]) ? a_a_r[2] : a_a_r[3];
    top_all = (top_01 > top_23) ? top_01 : top_23;
  end

  // ---- stage C: shifted magnitudes ----------------------------------------
  mag_t a_c_r [NCOMP];
  logic [NCOMP-1:0] neg_c_r;
  logic             zero_c_r, vld_c_r;

  // ---- stage D: squares ---------------------------------------------------
  logic [SQ_W-1:0] sq_d_r [NCOMP];
  mag_t a_d_r [NCOMP];
  logic [NCOMP-1:0] neg_d_r;
  logic             zero_d_r, vld_d_r;

  // ---- stage E: pair sums -------------------------------------------------
  logic [SUM_W-1:0] p01_e_r, p23_e_r;
  mag_t a_e_r [NCOMP];
  logic [NCOMP-1:0] neg_e_r;
  logic             zero_e_r, vld_e_r;

  // ---- stage F: total, divided by four ------------------------------------
  logic [SUM_W-1:0] sum_f;
  logic [RAD_W-1:0] rad_f_r;
  mag_t a_f_r [NCOMP];
  logic [NCOMP-1:0] neg_f_r;
  logic             zero_f_r, vld_f_r;

  assign sum_f = p01_e_r + p23_e_r;

  // ---- square root: one result bit per stage ------------------------------
  logic [SREM_W-1:0] s_rem_r  [ROOT_W];
  logic [ROOT_W-1:0] s_root_r [ROOT_W];
  logic [RADP_W-1:0] s_rad_r  [ROOT_W];
  mag_t              s_mag_r  [ROOT_W][NCOMP];
  logic [NCOMP-1:0]  s_neg_r  [ROOT_W];
  logic [ROOT_W-1:0] s_zero_r, s_vld_r;

  logic [SREM_W-1:0] s_rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] s_root_nxt [ROOT_W];
  logic [RADP_W-1:0] s_rad_nxt  [ROOT_W];

  always_comb begin
    logic [SREM_W-1:0] rem_in, r2, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RADP_W-1:0] rad_in;
    logic              ge;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = RADP_W'(rad_f_r);
      end else begin
        rem_in  = s_rem_r[k-1];
        root_in = s_root_r[k-1];
        rad_in  = s_rad_r[k-1];
      end
      // Bring down the next digit pair, try root*4+1.
      r2    = {rem_in[SREM_W-3:0], rad_in[RADP_W-1 -: 2]};
      trial = {{(SREM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
      ge    = (r2 >= trial);
      s_rem_nxt[k]  = ge ? (r2 - trial) : r2;
      s_root_nxt[k] = {root_in[ROOT_W-2:0], ge};
      s_rad_nxt[k]  = {rad_in[RADP_W-3:0], 2'b00};
    end
  end

  // ---- stage G: dividends and divisor -------------------------------------
  logic [NUM_W-1:0] num_g_r [NCOMP];
  logic [DIV_W-1:0] dv_g_r;
  logic [NCOMP-1:0] neg_g_r;
  logic             zero_g_r, vld_g_r;

  logic [ROOT_W-1:0] root_fin;
  assign root_fin = s_root_r[ROOT_W-1];

  // ---- divide: one quotient bit per stage, four lanes ---------------------
  logic [DIV_W-1:0] d_rem_r [QUO_W][NCOMP];
  logic [QUO_W-1:0] d_low_r [QUO_W][NCOMP];
  logic [QUO_W-1:0] d_quo_r [QUO_W][NCOMP];
  logic [DIV_W-1:0] d_dv_r  [QUO_W];
  logic [NCOMP-1:0] d_neg_r [QUO_W];
  logic [QUO_W-1:0] d_zero_r, d_vld_r;

  logic [DIV_W-1:0] d_rem_nxt [QUO_W][NCOMP];
  logic [QUO_W-1:0] d_low_nxt [QUO_W][NCOMP];
  logic [QUO_W-1:0] d_quo_nxt [QUO_W][NCOMP];

  always_comb begin
    logic [DIV_W-1:0] rem_in, dv_in;
    logic [QUO_W-1:0] low_in, quo_in;
    logic [DIV_W:0]   r2, diff;
    logic             ge;
    for (int k = 0; k < QUO_W; k++) begin
      for (int i = 0; i < NCOMP; i++) begin
        if (k == 0) begin
          rem_in = DIV_W'(num_g_r[i][NUM_W-1:QUO_W]);
          low_in = num_g_r[i][QUO_W-1:0];
          quo_in = '0;
          dv_in  = dv_g_r;
        end else begin
          rem_in = d_rem_r[k-1][i];
          low_in = d_low_r[k-1][i];
          quo_in = d_quo_r[k-1][i];
          dv_in  = d_dv_r[k-1];
        end
        r2   = {rem_in, low_in[QUO_W-1]};
        diff = r2 - {1'b0, dv_in};
        ge   = (r2 >= {1'b0, dv_in});
        d_rem_nxt[k][i] = ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
        d_low_nxt[k][i] = {low_in[QUO_W-2:0], 1'b0};
        d_quo_nxt[k][i] = {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  // ---- output: saturate, restore sign, zero case --------------------------
  comp_t out_unit_r [NCOMP];
  logic  out_zero_r;
  comp_t unit_nxt   [NCOMP];

  always_comb begin
    mag_t q, qs;
    for (int i = 0; i < NCOMP; i++) begin
      q  = d_quo_r[QUO_W-1][i];
      qs = (q > UNIT_ONE) ? UNIT_ONE : q;
      unit_nxt[i] = d_neg_r[QUO_W-1][i] ? comp_t'(-qs) : comp_t'(qs);
      if (d_zero_r[QUO_W-1]) unit_nxt[i] = (i == 0) ? comp_t'(UNIT_ONE) : '0;
    end
  end

  // ---- valid bits ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
      vld_c_r   <= 1'b0;
      vld_d_r   <= 1'b0;
      vld_e_r   <= 1'b0;
      vld_f_r   <= 1'b0;
      s_vld_r   <= '0;
      vld_g_r   <= 1'b0;
      d_vld_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_a_r   <= in_ch.valid;
      vld_b_r   <= vld_a_r;
      vld_c_r   <= vld_b_r;
      vld_d_r   <= vld_c_r;
      vld_e_r   <= vld_d_r;
      vld_f_r   <= vld_e_r;
      s_vld_r   <= {s_vld_r[ROOT_W-2:0], vld_f_r};
      vld_g_r   <= s_vld_r[ROOT_W-1];
      d_vld_r   <= {d_vld_r[QUO_W-2:0], vld_g_r};
      out_vld_r <= d_vld_r[QUO_W-1];
    end
  end

  // ---- data path registers (hold while stalled) ---------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NCOMP; i++) begin
        a_a_r[i]   <= in_comp[i][COMP_W-1] ? mag_t'(-in_comp[i]) : mag_t'(in_comp[i]);
        neg_a_r[i] <= in_comp[i][COMP_W-1];
        a_b_r[i]   <= a_a_r[i];
        a_c_r[i]   <= a_b_r[i] << sh_b_r;
        sq_d_r[i]  <= SQ_W'(a_c_r[i]) * SQ_W'(a_c_r[i]);
        a_d_r[i]   <= a_c_r[i];
        a_e_r[i]   <= a_d_r[i];
        a_f_r[i]   <= a_e_r[i];
        num_g_r[i] <= {s_mag_r[ROOT_W-1][i], {OUT_FRAC_BITS{1'b0}}} + NUM_W'(root_fin);
      end
      sh_b_r   <= norm_shift(top_all);
      neg_b_r  <= neg_a_r;
      zero_b_r <= (top_all == '0);
      neg_c_r  <= neg_b_r;
      zero_c_r <= zero_b_r;
      neg_d_r  <= neg_c_r;
      zero_d_r <= zero_c_r;
      p01_e_r  <= SUM_W'(sq_d_r[0]) + SUM_W'(sq_d_r[1]);
      p23_e_r  <= SUM_W'(sq_d_r[2]) + SUM_W'(sq_d_r[3]);
      neg_e_r  <= neg_d_r;
      zero_e_r <= zero_d_r;
      rad_f_r  <= sum_f[SUM_W-1:2];
      neg_f_r  <= neg_e_r;
      zero_f_r <= zero_e_r;

      for (int k = 0; k < ROOT_W; k++) begin
        s_rem_r[k]  <= s_rem_nxt[k];
        s_root_r[k] <= s_root_nxt[k];
        s_rad_r[k]  <= s_rad_nxt[k];
        if (k == 0) begin
          s_mag_r[k]  <= a_f_r;
          s_neg_r[k]  <= neg_f_r;
          s_zero_r[k] <= zero_f_r;
        end else begin
          s_mag_r[k]  <= s_mag_r[k-1];
          s_neg_r[k]  <= s_neg_r[k-1];
          s_zero_r[k] <= s_zero_r[k-1];
        end
      end

      dv_g_r   <= {root_fin, 1'b0};
      neg_g_r  <= s_neg_r[ROOT_W-1];
      zero_g_r <= s_zero_r[ROOT_W-1];

      for (int k = 0; k < QUO_W; k++) begin
        d_rem_r[k] <= d_rem_nxt[k];
        d_low_r[k] <= d_low_nxt[k];
        d_quo_r[k] <= d_quo_nxt[k];
        if (k == 0) begin
          d_dv_r[k]   <= dv_g_r;
          d_neg_r[k]  <= neg_g_r;
          d_zero_r[k] <= zero_g_r;
        end else begin
          d_dv_r[k]   <= d_dv_r[k-1];
          d_neg_r[k]  <= d_neg_r[k-1];
          d_zero_r[k] <= d_zero_r[k-1];
        end
      end

      out_unit_r <= unit_nxt;
      out_zero_r <= d_zero_r[QUO_W-1];
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.unit_w   = out_unit_r[0];
  assign out_ch.unit_x   = out_unit_r[1];
  assign out_ch.unit_y   = out_unit_r[2];
  assign out_ch.unit_z   = out_unit_r[3];
  assign out_ch.was_zero = out_zero_r;

  // ---- assertions ---------------------------------------------------------
  logic ident_ok, root_live, root_hi_ok, w_in_range;

  assign ident_ok   = (out_ch.unit_w == comp_t'(UNIT_ONE)) && (out_ch.unit_x == '0) &&
                      (out_ch.unit_y == '0) && (out_ch.unit_z == '0);
  assign root_live  = s_vld_r[ROOT_W-1] && !s_zero_r[ROOT_W-1];
  assign root_hi_ok = (root_fin[ROOT_W-1 -: 3] != '0);
  assign w_in_range = (out_ch.unit_w <= comp_t'(UNIT_ONE)) &&
                      (out_ch.unit_w >= -comp_t'(UNIT_ONE));

  // A zero quaternion must come out as the identity.
  `QN_ASSERT_IMPL(a_zero_ident, out_ch.valid && out_ch.was_zero, ident_ok, "zero not identity")
  // After normalization the root of a nonzero input is at least 2^(ROOT_W-3).
  `QN_ASSERT_IMPL(a_root_floor, root_live, root_hi_ok, "root below normalized floor")
  // Saturation keeps the scalar part within plus/minus one.
  `QN_ASSERT_IMPL(a_w_range, out_ch.valid, w_in_range, "unit_w outside plus/minus one")
  // An accepted beat must occupy the first stage on the next cycle.
  `QN_ASSERT_NEXT(a_enter, in_ch.valid && in_ch.ready, vld_a_r, "accepted beat lost at entry")

endmodule
